### rtl/cdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Critically damped follower package
// Shared widths, constants, beat types, datapath commands and the controller
// state encoding for the critically damped follower unit.
// ----------------------------------------------------------------------------
package cdf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    // Signed working width of the datapath; all intermediates stay below 2^59.
    localparam int VAL_W     = 60;
    // Multiplier operand B width and digit size.
    localparam int B_W       = 40;
    localparam int DIGIT_W   = 8;
    localparam int DIGITS    = B_W / DIGIT_W;
    localparam int PROD_W    = VAL_W + B_W;
    localparam int MCNT_W    = $clog2(DIGITS + 1);
    // Quotient width for 2^(2F+1) / divisor.
    localparam int QUO_W     = 2 * FRAC_BITS + 2;
    localparam int DCNT_W    = $clog2(QUO_W + 1);
    // Products that reach 2^64 before the shift saturate.
    localparam int OVF_BIT   = 64;

    localparam int CFG_IDX_W = 2;
    localparam int SPEED_W   = 31;
    localparam int STEP_W    = 17;

    localparam logic [VAL_W-1:0] LIM   = VAL_W'(1) << 56;
    localparam logic [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;

    localparam int C048_I   = (48 * (1 << FRAC_BITS) + 50) / 100;
    localparam int C0235_I  = (235 * (1 << FRAC_BITS) + 500) / 1000;
    localparam int TFL_RAW  = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam int TFL_I    = (TFL_RAW < 1) ? 1 : TFL_RAW;

    localparam logic [B_W-1:0]    C048    = B_W'(C048_I);
    localparam logic [B_W-1:0]    C0235   = B_W'(C0235_I);
    localparam logic [WORD_W-1:0] T_FLOOR = WORD_W'(TFL_I);

    localparam logic [QUO_W-1:0] DVD_RATE  = {2'b10, {(2 * FRAC_BITS){1'b0}}};
    localparam logic [QUO_W-1:0] DVD_DECAY = {2'b01, {(2 * FRAC_BITS){1'b0}}};

    localparam logic [WORD_W-1:0]  RST_SMOOTHING = WORD_W'(19661);
    localparam logic [SPEED_W-1:0] RST_SPEED     = SPEED_W'(31'h7FFF_FFFF);
    localparam logic [STEP_W-1:0]  RST_STEP      = STEP_W'(1092);

    localparam logic signed [VAL_W-1:0] S32_MAX = VAL_W'(signed'(32'h7FFF_FFFF));
    localparam logic signed [VAL_W-1:0] S32_MIN = VAL_W'(signed'(32'h8000_0000));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTHING = 2'd0,
        REG_SPEED     = 2'd1,
        REG_STEP      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] position_now;
        logic signed [WORD_W-1:0] goal;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] position_next;
        logic signed [WORD_W-1:0] velocity_next;
        logic                     snapped;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_DIV_RATE,
        OP_MUL_X,
        OP_MUL_X2,
        OP_MUL_X3,
        OP_MUL_T48,
        OP_MUL_T235,
        OP_DIV_DECAY,
        OP_MUL_LIM,
        OP_MUL_S1,
        OP_MUL_T7,
        OP_MUL_S2,
        OP_MUL_VN,
        OP_MUL_P
    } dp_op_t;

    typedef enum logic [3:0] {
        S_DIV_R,
        S_MUL_X,
        S_MUL_X2,
        S_MUL_X3,
        S_MUL_T48,
        S_MUL_T235,
        S_DIV_D,
        S_MUL_LIM,
        S_IDLE,
        S_MUL_S1,
        S_MUL_T7,
        S_MUL_S2,
        S_MUL_VN,
        S_MUL_P,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic   start;
        dp_op_t op;
        logic   load;
        logic   finish;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_busy;
    } dp_status_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [VAL_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > S32_MAX)
        begin
            r = signed'(32'h7FFF_FFFF);
        end
        else if (v < S32_MIN)
        begin
            r = signed'(32'h8000_0000);
        end
        else
        begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/cdf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Digit-serial saturating fixed-point multiplier
// Multiplies a signed operand by an unsigned one, one 8-bit digit of the
// unsigned operand per cycle, then shifts out the fraction and saturates.
// ----------------------------------------------------------------------------
module cdf_mul
    import cdf_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [VAL_W-1:0] a,
    input  wire logic [B_W-1:0]          b,
    output logic                         done,
    output logic signed [VAL_W-1:0]      result
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [MCNT_W-1:0]     cnt_reg;
    logic                  neg_reg;
    logic [VAL_W-1:0]      a_mag_reg;
    logic [B_W-1:0]        b_reg;
    logic [PROD_W-1:0]     acc_reg;

    logic [VAL_W+DIGIT_W-1:0] pp;
    logic [PROD_W-1:0]        acc_next;
    logic [PROD_W-1:0]        shifted;
    logic                     ovf;
    logic [VAL_W-1:0]         mag;

    always_comb
    begin
        pp       = a_mag_reg * b_reg[B_W-1 -: DIGIT_W];
        acc_next = (acc_reg << DIGIT_W) + PROD_W'(pp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MCNT_W'(DIGITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - MCNT_W'(1);
                if (cnt_reg == MCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg   <= a[VAL_W-1];
            a_mag_reg <= a[VAL_W-1] ? VAL_W'(-a) : VAL_W'(a);
            b_reg     <= b;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << DIGIT_W;
        end
    end

    always_comb
    begin
        ovf     = |acc_reg[PROD_W-1:OVF_BIT];
        shifted = acc_reg >> FRAC_BITS;
        if (ovf || (shifted > PROD_W'(LIM)))
        begin
            mag = LIM;
        end
        else
        begin
            mag = shifted[VAL_W-1:0];
        end
        result = neg_reg ? -signed'(mag) : signed'(mag);
    end

    assign done = done_reg;

endmodule
`default_nettype wire

### rtl/cdf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, truncated quotient.
// ----------------------------------------------------------------------------
module cdf_div
    import cdf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [QUO_W-1:0]  dividend,
    input  wire logic [VAL_W-1:0]  divisor,
    output logic                   done,
    output logic [QUO_W-1:0]       quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [QUO_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [VAL_W-1:0]  rem_reg;
    logic [VAL_W-1:0]  dsr_reg;

    logic [VAL_W-1:0]  trial;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg[VAL_W-2:0], dvd_reg[QUO_W-1]};
        fits  = (trial >= dsr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= fits ? (trial - dsr_reg) : trial;
            q_reg   <= {q_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

### rtl/cdf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Critically damped follower datapath
// Configuration registers, derived coefficients, working registers, the
// shared multiplier and divider, and the output register.
// ----------------------------------------------------------------------------
module cdf_datapath
    import cdf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data,
    input  wire in_item_t             in_data,
    input  wire logic                 out_stall,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic                      out_valid,
    output out_item_t                 out_data
);

    logic [WORD_W-1:0]  smoothing_time_reg;
    logic [SPEED_W-1:0] speed_limit_reg;
    logic [STEP_W-1:0]  time_step_reg;
    logic signed [WORD_W-1:0] velocity_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic [WORD_W-1:0]  rate_reg;
    logic [WORD_W-1:0]  decay_reg;
    dp_op_t             op_reg;

    logic signed [VAL_W-1:0] x_reg, x2_reg, x3_reg, t48_reg, lim_reg;
    logic [VAL_W-1:0]        den_reg;
    logic signed [WORD_W-1:0] cur_reg, tgt_reg;
    logic signed [VAL_W-1:0] off_reg, adj_reg, w1_reg, t7_reg, w2_reg, w3_reg;
    logic signed [VAL_W-1:0] vn_reg, pos_reg;

    logic [WORD_W-1:0]       t_floor;
    logic signed [VAL_W-1:0] v_ext;
    logic signed [VAL_W-1:0] mul_a;
    logic [B_W-1:0]          mul_b;
    logic                    mul_start, mul_done;
    logic signed [VAL_W-1:0] mul_res;
    logic                    div_start, div_done;
    logic [QUO_W-1:0]        div_dvd, div_q;
    logic [VAL_W-1:0]        div_dsr;

    logic signed [VAL_W-1:0] cur_ext, tgt_ext, diff, off_load;
    logic                    snap;
    logic signed [VAL_W-1:0] pos_sel, vn_sel;
    logic signed [WORD_W-1:0] vn_sat;

    assign t_floor = (smoothing_time_reg < T_FLOOR) ? T_FLOOR : smoothing_time_reg;
    assign v_ext   = VAL_W'(velocity_reg);

    // Operand selection for the shared units.
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_dvd = DVD_RATE;
        div_dsr = VAL_W'(t_floor);
        case (cmd.op)
            OP_MUL_X:
            begin
                mul_a = VAL_W'(rate_reg);
                mul_b = B_W'(time_step_reg);
            end
            OP_MUL_X2:
            begin
                mul_a = x_reg;
                mul_b = x_reg[B_W-1:0];
            end
            OP_MUL_X3:
            begin
                mul_a = x2_reg;
                mul_b = x_reg[B_W-1:0];
            end
            OP_MUL_T48:
            begin
                mul_a = x2_reg;
                mul_b = C048;
            end
            OP_MUL_T235:
            begin
                mul_a = x3_reg;
                mul_b = C0235;
            end
            OP_MUL_LIM:
            begin
                mul_a = VAL_W'(speed_limit_reg);
                mul_b = B_W'(t_floor);
            end
            OP_MUL_S1:
            begin
                mul_a = off_reg;
                mul_b = B_W'(rate_reg);
            end
            OP_MUL_T7:
            begin
                mul_a = w1_reg;
                mul_b = B_W'(time_step_reg);
            end
            OP_MUL_S2:
            begin
                mul_a = t7_reg;
                mul_b = B_W'(rate_reg);
            end
            OP_MUL_VN:
            begin
                mul_a = w2_reg;
                mul_b = B_W'(decay_reg);
            end
            OP_MUL_P:
            begin
                mul_a = w3_reg;
                mul_b = B_W'(decay_reg);
            end
            OP_DIV_DECAY:
            begin
                div_dvd = DVD_DECAY;
                div_dsr = den_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign div_start = cmd.start && (cmd.op inside {OP_DIV_RATE, OP_DIV_DECAY});
    assign mul_start = cmd.start && !(cmd.op inside {OP_DIV_RATE, OP_DIV_DECAY, OP_NONE});

    cdf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    cdf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // Offset to the goal, clamped to the speed limit times the smoothing time.
    always_comb
    begin
        cur_ext = VAL_W'(in_data.position_now);
        tgt_ext = VAL_W'(in_data.goal);
        diff    = cur_ext - tgt_ext;
        if (diff > lim_reg)
        begin
            off_load = lim_reg;
        end
        else if (diff < -lim_reg)
        begin
            off_load = -lim_reg;
        end
        else
        begin
            off_load = diff;
        end
    end

    // Overshoot test and snap.
    always_comb
    begin
        snap    = ((tgt_reg > cur_reg) == (pos_reg > VAL_W'(tgt_reg)));
        pos_sel = snap ? VAL_W'(tgt_reg) : pos_reg;
        vn_sel  = snap ? '0 : vn_reg;
        vn_sat  = sat32(vn_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_time_reg <= RST_SMOOTHING;
            speed_limit_reg    <= RST_SPEED;
            time_step_reg      <= RST_STEP;
            velocity_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SMOOTHING: smoothing_time_reg <= cfg_data;
                    REG_SPEED:     speed_limit_reg    <= cfg_data[SPEED_W-1:0];
                    REG_STEP:      time_step_reg      <= cfg_data[STEP_W-1:0];
                    default:       smoothing_time_reg <= smoothing_time_reg;
                endcase
            end
            if (cmd.finish)
            begin
                velocity_reg  <= vn_sat;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= cmd.op;
        end
        if (cmd.load)
        begin
            cur_reg <= in_data.position_now;
            tgt_reg <= in_data.goal;
            off_reg <= off_load;
            adj_reg <= cur_ext - off_load;
        end
        if (cmd.finish)
        begin
            out_data_reg.position_next <= sat32(pos_sel);
            out_data_reg.velocity_next <= vn_sat;
            out_data_reg.snapped       <= snap;
        end
        if (div_done)
        begin
            case (op_reg)
                OP_DIV_RATE:  rate_reg  <= (|div_q[QUO_W-1:WORD_W]) ? '1 : div_q[WORD_W-1:0];
                OP_DIV_DECAY: decay_reg <= div_q[WORD_W-1:0];
                default:      rate_reg  <= rate_reg;
            endcase
        end
        if (mul_done)
        begin
            case (op_reg)
                OP_MUL_X:    x_reg   <= mul_res;
                OP_MUL_X2:   x2_reg  <= mul_res;
                OP_MUL_X3:   x3_reg  <= mul_res;
                OP_MUL_T48:  t48_reg <= mul_res;
                OP_MUL_T235: den_reg <= VAL_W'(ONE_Q + x_reg + t48_reg + mul_res);
                OP_MUL_LIM:  lim_reg <= mul_res;
                OP_MUL_S1:   w1_reg  <= v_ext + mul_res;
                OP_MUL_T7:
                begin
                    t7_reg <= mul_res;
                    w3_reg <= off_reg + mul_res;
                end
                OP_MUL_S2:   w2_reg  <= v_ext - mul_res;
                OP_MUL_VN:   vn_reg  <= mul_res;
                OP_MUL_P:    pos_reg <= adj_reg + mul_res;
                default:     x_reg   <= x_reg;
            endcase
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule
`default_nettype wire

### rtl/cdf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Critically damped follower controller
// Sequences coefficient derivation and the per-beat update through the
// shared multiplier and divider.
// ----------------------------------------------------------------------------
module cdf_ctrl
    import cdf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       cfg_write,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            in_stall
);

    ctrl_state_t state_reg, state_next;
    logic        go_reg, go_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_DIV_R;
            go_reg    <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        go_next    = 1'b0;
        cmd.start  = go_reg;
        cmd.op     = OP_NONE;
        cmd.load   = 1'b0;
        cmd.finish = 1'b0;
        in_stall   = (state_reg != S_IDLE) || cfg_write;

        case (state_reg)
            S_DIV_R:    cmd.op = OP_DIV_RATE;
            S_MUL_X:    cmd.op = OP_MUL_X;
            S_MUL_X2:   cmd.op = OP_MUL_X2;
            S_MUL_X3:   cmd.op = OP_MUL_X3;
            S_MUL_T48:  cmd.op = OP_MUL_T48;
            S_MUL_T235: cmd.op = OP_MUL_T235;
            S_DIV_D:    cmd.op = OP_DIV_DECAY;
            S_MUL_LIM:  cmd.op = OP_MUL_LIM;
            S_MUL_S1:   cmd.op = OP_MUL_S1;
            S_MUL_T7:   cmd.op = OP_MUL_T7;
            S_MUL_S2:   cmd.op = OP_MUL_S2;
            S_MUL_VN:   cmd.op = OP_MUL_VN;
            S_MUL_P:    cmd.op = OP_MUL_P;
            default:    cmd.op = OP_NONE;
        endcase

        // A unit's done is ignored in the cycle that starts the next operation.
        case (state_reg)
            S_DIV_R:
            begin
                if (!go_reg && status.div_done)
                begin
                    state_next = S_MUL_X;
                    go_next    = 1'b1;
                end
            end
            S_MUL_X:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_X2;
                    go_next    = 1'b1;
                end
            end
            S_MUL_X2:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_X3;
                    go_next    = 1'b1;
                end
            end
            S_MUL_X3:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_T48;
                    go_next    = 1'b1;
                end
            end
            S_MUL_T48:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_T235;
                    go_next    = 1'b1;
                end
            end
            S_MUL_T235:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_DIV_D;
                    go_next    = 1'b1;
                end
            end
            S_DIV_D:
            begin
                if (!go_reg && status.div_done)
                begin
                    state_next = S_MUL_LIM;
                    go_next    = 1'b1;
                end
            end
            S_MUL_LIM:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !cfg_write)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_S1;
                    go_next    = 1'b1;
                end
            end
            S_MUL_S1:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_T7;
                    go_next    = 1'b1;
                end
            end
            S_MUL_T7:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_S2;
                    go_next    = 1'b1;
                end
            end
            S_MUL_S2:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_VN;
                    go_next    = 1'b1;
                end
            end
            S_MUL_VN:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_MUL_P;
                    go_next    = 1'b1;
                end
            end
            S_MUL_P:
            begin
                if (!go_reg && status.mul_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_DIV_R;
                go_next    = 1'b1;
            end
        endcase

        // Any register write restarts the coefficient derivation.
        if (cfg_write)
        begin
            state_next = S_DIV_R;
            go_next    = 1'b1;
        end
    end

endmodule
`default_nettype wire

### rtl/critically_damped_follower_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Critically damped follower unit
// One critically damped spring step per input beat, in signed Q16.16.
// ----------------------------------------------------------------------------
// Each input beat carries a current position and a goal; the unit keeps the
// velocity between beats and returns one result beat with the new position,
// the new velocity and a snapped flag that is set when the step would pass
// the goal. After reset and after every register write the unit derives 2/T
// and the decay factor with one divider pass, five multiplies, a second
// divider pass and one more multiply for the offset limit; input beats are
// stalled meanwhile. Each accepted beat then runs five dependent multiplies
// through one shared multiplier, each made of a start step, the steps that
// consume the 40-bit operand in 8-bit digits, and a write-back step, while
// further input beats are stalled. The finish step then fills the output
// register, and the idle state accepts the next beat. The finish step waits
// for as long as an earlier result is stalled in the output register. The
// next beat is accepted while the previous result still waits in the output
// register.
// ----------------------------------------------------------------------------
module critically_damped_follower_unit
    import cdf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Input channel.
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    // Result channel.
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_item_t                 out_data,
    // Configuration write port: 0 smoothing time, 1 speed limit, 2 time step.
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]    cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller only sequences; all arithmetic lives in the datapath.
    cdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_write (cfg_write),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall)
    );

    cdf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
